### rtl/core/bgrlh_pkg.sv
package bgrlh_pkg;

  // Field widths fixed by the channel definitions
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LUMA_W    = 8;
  localparam int unsigned BIN_IDX_W = 4;
  localparam int unsigned BIN_CNT_W = 22;

  // Q16 weights: BT.601 coefficients scaled by 219/255
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned PROD_W   = PIX_W + WEIGHT_W;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd6416;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd33039;
  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd16829;
  localparam logic [LUMA_W-1:0]   LUMA_OFFSET = 8'd16;
  localparam int unsigned BIN_SHIFT = 4;

  // Result kind codes
  localparam logic KIND_LUMA = 1'b0;
  localparam logic KIND_BIN  = 1'b1;

  typedef struct packed {
    logic load_pix;    // capture pixel, restart dump index
    logic mul;         // register the three weighted products
    logic sum;         // form luma, read bin counter
    logic wr_cnt;      // write incremented counter back
    logic out_luma;    // load luma result into output register
    logic rd_dump;     // read counter at dump index
    logic out_bin;     // load bin result into output register
    logic idx_inc;     // advance dump index
    logic clear_bins;  // invalidate all counters
  } cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a new item this cycle
    logic eof;         // captured pixel ends its frame
    logic idx_last;    // dump index points at the top bin
  } status_t;

endpackage

### rtl/core/bgrlh_if.sv
interface bgrlh_pix_if;
  import bgrlh_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;
  logic             end_of_frame;

  modport source (output valid, blue, green, red, end_of_frame, input ready);
  modport sink (input valid, blue, green, red, end_of_frame, output ready);
endinterface

interface bgrlh_res_if;
  import bgrlh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [LUMA_W-1:0]    luma;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [BIN_CNT_W-1:0] bin_count;
  logic                 last;

  modport source (output valid, kind, luma, bin_index, bin_count, last, input ready);
  modport sink (input valid, kind, luma, bin_index, bin_count, last, output ready);
endinterface

### rtl/core/bgr_luma_with_histogram.sv
// BGR pixel to studio-range luma with a per-frame luma histogram.
// Input channel pix_i: one pixel per item (blue, green, red, end_of_frame).
// Output channel res_o: for every pixel one luma item (kind 0), and after a
// pixel with end_of_frame set, NUM_BINS bin items (kind 1) in bin order;
// last marks the final item caused by each pixel. Bin counts saturate.
// The luma item passes the pixel, product and luma registers before it is loaded into the output register.
// Pixels are taken one at a time: the multiply, sum/counter read and counter
// write steps of one pixel all finish before the next pixel is accepted.
// A frame end adds a dump (read, then send each count); the counters are then
// cleared for the next frame in the same cycle as the top bin is sent.
// A new pixel is taken while a finished result still sits in the output
// register; if res_o stalls, the block holds at the next result to send and
// drops pix_i.ready until that result has moved on.
// Reset clears all bin counts, the output valid and the controller.
module bgr_luma_with_histogram import bgrlh_pkg::*; #(
  parameter int unsigned NUM_BINS    = 16,
  parameter int unsigned COUNT_WIDTH = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgrlh_pix_if.sink   pix_i,
  bgrlh_res_if.source res_o
);

  cmd_t    cmd;
  status_t sts;

  bgrlh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bgrlh_dp #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .blue_i          (pix_i.blue),
    .green_i         (pix_i.green),
    .red_i           (pix_i.red),
    .eof_i           (pix_i.end_of_frame),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .out_kind_o      (res_o.kind),
    .out_luma_o      (res_o.luma),
    .out_bin_index_o (res_o.bin_index),
    .out_bin_count_o (res_o.bin_count),
    .out_last_o      (res_o.last)
  );

endmodule

### rtl/core/bgrlh_ctrl.sv
module bgrlh_ctrl import bgrlh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  input  status_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_UPD,
    S_DRD,
    S_DWR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        // hold the counter update until the luma item has a place to go
        if (sts_i.out_free) begin
          cmd_o.wr_cnt   = 1'b1;
          cmd_o.out_luma = 1'b1;
          state_d        = sts_i.eof ? S_DRD : S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.rd_dump = 1'b1;
        state_d       = S_DWR;
      end
      S_DWR: begin
        if (sts_i.out_free) begin
          cmd_o.out_bin = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear_bins = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_pixel_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("pixel accepted while previous one still in flight");

  a_clear_after_top_bin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_bins |-> (cmd_o.out_bin && sts_i.idx_last)
  ) else $error("bins cleared before the top bin was sent");

  a_write_before_dump: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_cnt && sts_i.eof) |=> cmd_o.rd_dump
  ) else $error("dump did not follow the last pixel of a frame");

endmodule

### rtl/core/bgrlh_dp.sv
module bgrlh_dp import bgrlh_pkg::*; #(
  parameter int unsigned NUM_BINS    = 16,
  parameter int unsigned COUNT_WIDTH = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              sts_o,
  input  logic [PIX_W-1:0]     blue_i,
  input  logic [PIX_W-1:0]     green_i,
  input  logic [PIX_W-1:0]     red_i,
  input  logic                 eof_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_kind_o,
  output logic [LUMA_W-1:0]    out_luma_o,
  output logic [BIN_IDX_W-1:0] out_bin_index_o,
  output logic [BIN_CNT_W-1:0] out_bin_count_o,
  output logic                 out_last_o
);

  localparam int unsigned IdxW = $clog2(NUM_BINS);

  logic [PIX_W-1:0]       blue_q, green_q, red_q;
  logic                   eof_q;
  logic [PROD_W-1:0]      prod_b_q, prod_g_q, prod_r_q;
  logic [PROD_W-1:0]      sum_d;
  logic [LUMA_W-1:0]      y_d, y_q;
  logic [BIN_IDX_W-1:0]   bin_raw;
  logic [IdxW-1:0]        bin_d, bin_q;
  logic [IdxW-1:0]        idx_q;
  logic [IdxW-1:0]        rd_addr;
  logic                   idx_last;
  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]    valid_q;
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_valid_q;
  logic [COUNT_WIDTH-1:0] cnt_cur, cnt_inc;
  logic                   out_valid_q;
  logic                   out_free;

  // Luma and bin selection
  assign sum_d   = prod_b_q + prod_g_q + prod_r_q;
  assign y_d     = sum_d[PROD_W-1 -: LUMA_W] + LUMA_OFFSET;
  assign bin_raw = y_d[LUMA_W-1 -: BIN_IDX_W];

  always_comb begin
    if ({5'd0, bin_raw} >= 9'(NUM_BINS)) begin
      bin_d = IdxW'(NUM_BINS - 1);
    end else begin
      bin_d = IdxW'(bin_raw);
    end
  end

  assign rd_addr  = cmd_i.rd_dump ? idx_q : bin_d;
  assign idx_last = (idx_q == IdxW'(NUM_BINS - 1));
  assign cnt_cur  = rd_valid_q ? rd_data_q : '0;
  assign cnt_inc  = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.out_free = out_free;
  assign sts_o.eof      = eof_q;
  assign sts_o.idx_last = idx_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      blue_q  <= blue_i;
      green_q <= green_i;
      red_q   <= red_i;
      eof_q   <= eof_i;
    end
    if (cmd_i.mul) begin
      prod_b_q <= {{WEIGHT_W{1'b0}}, blue_q}  * {{PIX_W{1'b0}}, W_BLUE};
      prod_g_q <= {{WEIGHT_W{1'b0}}, green_q} * {{PIX_W{1'b0}}, W_GREEN};
      prod_r_q <= {{WEIGHT_W{1'b0}}, red_q}   * {{PIX_W{1'b0}}, W_RED};
    end
    if (cmd_i.sum) begin
      y_q   <= y_d;
      bin_q <= bin_d;
    end
  end

  // Bin counter store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cnt) begin
      mem_q[bin_q] <= cnt_inc;
    end
    if (cmd_i.sum || cmd_i.rd_dump) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // An entry without its valid bit reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_bins) begin
      valid_q <= '0;
    end else if (cmd_i.wr_cnt) begin
      valid_q[bin_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load_pix) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_luma || cmd_i.out_bin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_luma) begin
      out_kind_o      <= KIND_LUMA;
      out_luma_o      <= y_q;
      out_bin_index_o <= '0;
      out_bin_count_o <= '0;
      out_last_o      <= !eof_q;
    end else if (cmd_i.out_bin) begin
      out_kind_o      <= KIND_BIN;
      out_luma_o      <= '0;
      out_bin_index_o <= BIN_IDX_W'(idx_q);
      out_bin_count_o <= BIN_CNT_W'(cnt_cur);
      out_last_o      <= idx_last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_clear_empties_bins: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_bins |=> (valid_q == '0)
  ) else $error("bins still valid after frame dump");

  a_luma_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_o == KIND_LUMA)) |->
      ((out_luma_o >= 8'd16) && (out_luma_o <= 8'd235))
  ) else $error("luma outside studio range");

  a_load_only_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_luma || cmd_i.out_bin) |-> out_free
  ) else $error("output register overwritten while stalled");

endmodule
